// File: rtl/core/csem_pkg.sv
// Shared types and constants for the counting semaphore table.
// Depends on nothing; imported by csem_ctrl, counting_semaphore_table and the testbench.
package csem_pkg;

   localparam int NUM_SEMS_DEF    = 16;
   localparam int QUEUE_DEPTH_DEF = 16;

   typedef enum logic [2:0] {
      MODE_OPEN     = 3'd0,
      MODE_OPEN_NEW = 3'd1,
      MODE_CLOSE    = 3'd2,
      MODE_POST     = 3'd3,
      MODE_WAIT     = 3'd4,
      MODE_PURGE    = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_QFULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] sem_id;
      logic [31:0] init_value;
      logic [15:0] proc_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        granted;
      logic        blocked;
      logic        woken_valid;
      logic [15:0] woken_proc;
      logic [15:0] assigned_id;
   } rsp_type;

endpackage

// File: rtl/core/counting_semaphore_table.sv
// Counting semaphore table: NUM_SEMS named semaphores, each with a FIFO wait
// queue of QUEUE_DEPTH process ids. Depends on csem_pkg, csem_ctrl, csem_ram.
//
// One command at a time. A transfer on req_ is taken only while the sequencer
// is idle; a result sits in the rsp_ output register, so the next command is
// taken while the previous result waits. Open, open new id, close, post and
// wait scan the slot RAM one slot per cycle (its single read port sets the
// pace); open, close, post and wait stop the scan when the id is found, and
// open new id scans every slot, then does a one-per-cycle search for the
// lowest free id. Purge walks all slots; for each used slot it reads the
// entry, reads each queued waiter and writes back the kept ones, then rewrites
// the slot's queue length. Unknown modes go straight to the result. Post hands
// the unit straight to the oldest waiter. Slot and queue stores need no
// clearing pass; only the used flags are reset.
module counting_semaphore_table
   import csem_pkg::*;
#(
   parameter int NUM_SEMS    = NUM_SEMS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = (NUM_SEMS * QUEUE_DEPTH > 1) ? $clog2(NUM_SEMS * QUEUE_DEPTH) : 1;
   localparam int EW = 48 + QW + LW;

   // slot RAM: {ident, count, head, len} per semaphore
   logic          slot_wr_en;
   logic [SW-1:0] slot_wr_addr;
   logic [EW-1:0] slot_wr_data;
   logic          slot_rd_en;
   logic [SW-1:0] slot_rd_addr;
   logic [EW-1:0] slot_rd_data;

   // wait store: QUEUE_DEPTH ring entries per slot
   logic          ws_wr_en;
   logic [AW-1:0] ws_wr_addr;
   logic [15:0]   ws_wr_data;
   logic          ws_rd_en;
   logic [AW-1:0] ws_rd_addr;
   logic [15:0]   ws_rd_data;

   csem_ctrl #(
      .NUM_SEMS    (NUM_SEMS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .slot_wr_en   (slot_wr_en),
      .slot_wr_addr (slot_wr_addr),
      .slot_wr_data (slot_wr_data),
      .slot_rd_en   (slot_rd_en),
      .slot_rd_addr (slot_rd_addr),
      .slot_rd_data (slot_rd_data),
      .ws_wr_en     (ws_wr_en),
      .ws_wr_addr   (ws_wr_addr),
      .ws_wr_data   (ws_wr_data),
      .ws_rd_en     (ws_rd_en),
      .ws_rd_addr   (ws_rd_addr),
      .ws_rd_data   (ws_rd_data)
   );

   csem_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_SEMS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   csem_ram #(
      .WIDTH (16),
      .DEPTH (NUM_SEMS * QUEUE_DEPTH)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (ws_wr_en),
      .wr_addr (ws_wr_addr),
      .wr_data (ws_wr_data),
      .rd_en   (ws_rd_en),
      .rd_addr (ws_rd_addr),
      .rd_data (ws_rd_data)
   );

`ifndef ASSERT_OFF
   // a taken command leaves the sequencer busy in the cycle after the transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a command transfer");

   // wait cannot both grant and block
   a_grant_xor_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.granted && rsp_payload.blocked))
      else $error("granted and blocked both set");

   // grant, block and wake only come with an ok status
   a_flags_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.granted || rsp_payload.blocked ||
                    rsp_payload.woken_valid) |-> rsp_payload.status == ST_OK)
      else $error("result flag set with error status");

   // woken process id is zero unless a waiter was released
   a_woken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.woken_valid |-> rsp_payload.woken_proc == 16'd0)
      else $error("woken_proc nonzero without woken_valid");
`endif

endmodule

// File: rtl/core/csem_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module csem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/csem_ctrl.sv
// Command sequencer and datapath of the semaphore table: slot scan, open/close, id pick,
// post/wait update and purge compaction. Depends on csem_pkg; drives two csem_ram.
module csem_ctrl
   import csem_pkg::*;
#(
   parameter int NUM_SEMS    = NUM_SEMS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1,
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int LW = $clog2(QUEUE_DEPTH + 1),
   localparam int CW = $clog2(NUM_SEMS + 1),
   localparam int AW = (NUM_SEMS * QUEUE_DEPTH > 1) ? $clog2(NUM_SEMS * QUEUE_DEPTH) : 1,
   localparam int EW = 48 + QW + LW
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_payload,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload,
   output logic          slot_wr_en,
   output logic [SW-1:0] slot_wr_addr,
   output logic [EW-1:0] slot_wr_data,
   output logic          slot_rd_en,
   output logic [SW-1:0] slot_rd_addr,
   input  logic [EW-1:0] slot_rd_data,
   output logic          ws_wr_en,
   output logic [AW-1:0] ws_wr_addr,
   output logic [15:0]   ws_wr_data,
   output logic          ws_rd_en,
   output logic [AW-1:0] ws_rd_addr,
   input  logic [15:0]   ws_rd_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_EXEC, S_CAND, S_WRD,
      S_PSLOT, S_PENT, S_PRD, S_PWR, S_RESP
   } state_type;

   state_type     state_ff, state_in;
   req_type       cmd_ff, cmd_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [NUM_SEMS-1:0] used_ff, used_in;
   logic [NUM_SEMS-1:0] taken_ff, taken_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          p_vld_ff, p_vld_in;
   logic [SW-1:0] p_idx_ff, p_idx_in;
   logic          found_ff, found_in;
   logic [SW-1:0] found_slot_ff, found_slot_in;
   logic          free_ok_ff, free_ok_in;
   logic [SW-1:0] free_slot_ff, free_slot_in;
   logic [EW-1:0] ent_ff, ent_in;
   logic [CW-1:0] cand_ff, cand_in;
   logic [CW-1:0] ps_ff, ps_in;
   logic [LW-1:0] pi_ff, pi_in;
   logic [LW-1:0] pn_ff, pn_in;

   logic [15:0]   rd_ident;
   logic [15:0]   ent_ident;
   logic [31:0]   ent_count;
   logic [QW-1:0] ent_head;
   logic [LW-1:0] ent_len;

   // entry layout: {ident, count, head, len}
   assign rd_ident  = slot_rd_data[EW-1 -: 16];
   assign ent_ident = ent_ff[EW-1 -: 16];
   assign ent_count = ent_ff[LW+QW +: 32];
   assign ent_head  = ent_ff[LW +: QW];
   assign ent_len   = ent_ff[LW-1:0];

   // sum of two in-range values, wrapped once into the ring
   function automatic logic [QW-1:0] qwrap(input logic [LW:0] sum);
      logic [LW:0] r;
      r = (sum >= (LW+1)'(QUEUE_DEPTH)) ? sum - (LW+1)'(QUEUE_DEPTH) : sum;
      return r[QW-1:0];
   endfunction

   function automatic logic [AW-1:0] ws_addr(input logic [SW-1:0] slot,
                                             input logic [QW-1:0] ptr);
      return AW'(slot) * AW'(QUEUE_DEPTH) + AW'(ptr);
   endfunction

   always_comb begin
      logic hit;
      hit           = 1'b0;
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      used_in       = used_ff;
      taken_in      = taken_ff;
      scan_idx_in   = scan_idx_ff;
      p_vld_in      = 1'b0;
      p_idx_in      = p_idx_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      free_ok_in    = free_ok_ff;
      free_slot_in  = free_slot_ff;
      ent_in        = ent_ff;
      cand_in       = cand_ff;
      ps_in         = ps_ff;
      pi_in         = pi_ff;
      pn_in         = pn_ff;
      slot_wr_en    = 1'b0;
      slot_wr_addr  = '0;
      slot_wr_data  = '0;
      slot_rd_en    = 1'b0;
      slot_rd_addr  = '0;
      ws_wr_en      = 1'b0;
      ws_wr_addr    = '0;
      ws_wr_data    = '0;
      ws_rd_en      = 1'b0;
      ws_rd_addr    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_payload;
               res_in      = '0;
               scan_idx_in = '0;
               found_in    = 1'b0;
               free_ok_in  = 1'b0;
               taken_in    = '0;
               ps_in       = '0;
               if (req_payload.mode == MODE_PURGE) begin
                  state_in = S_PSLOT;
               end else if (req_payload.mode == MODE_OPEN ||
                            req_payload.mode == MODE_OPEN_NEW ||
                            req_payload.mode == MODE_CLOSE ||
                            req_payload.mode == MODE_POST ||
                            req_payload.mode == MODE_WAIT) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end

         S_SCAN: begin
            // issue one slot read per cycle, check it the cycle after
            if (scan_idx_ff < CW'(NUM_SEMS)) begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = scan_idx_ff[SW-1:0];
               scan_idx_in  = scan_idx_ff + CW'(1);
               p_vld_in     = 1'b1;
               p_idx_in     = scan_idx_ff[SW-1:0];
            end
            if (p_vld_ff) begin
               hit = used_ff[p_idx_ff] && (rd_ident == cmd_ff.sem_id);
               if (hit && !found_ff) begin
                  found_in      = 1'b1;
                  found_slot_in = p_idx_ff;
                  ent_in        = slot_rd_data;
               end
               if (!used_ff[p_idx_ff] && !free_ok_ff) begin
                  free_ok_in   = 1'b1;
                  free_slot_in = p_idx_ff;
               end
               if (used_ff[p_idx_ff] && rd_ident < 16'(NUM_SEMS)) begin
                  taken_in[rd_ident[SW-1:0]] = 1'b1;
               end
               if (p_idx_ff == SW'(NUM_SEMS - 1) ||
                   (hit && cmd_ff.mode != MODE_OPEN_NEW)) begin
                  state_in = S_EXEC;
                  p_vld_in = 1'b0;
               end
            end
         end

         S_EXEC: begin
            state_in = S_RESP;
            unique case (cmd_ff.mode)
               MODE_OPEN: begin
                  if (!found_ff) begin
                     if (!free_ok_ff) begin
                        res_in.status = ST_FULL;
                     end else begin
                        slot_wr_en            = 1'b1;
                        slot_wr_addr          = free_slot_ff;
                        slot_wr_data          = {cmd_ff.sem_id, cmd_ff.init_value,
                                                 {QW{1'b0}}, {LW{1'b0}}};
                        used_in[free_slot_ff] = 1'b1;
                     end
                  end
               end
               MODE_OPEN_NEW: begin
                  if (!free_ok_ff) begin
                     res_in.status = ST_FULL;
                  end else begin
                     cand_in  = CW'(1);
                     state_in = S_CAND;
                  end
               end
               MODE_CLOSE: begin
                  if (found_ff) begin
                     used_in[found_slot_ff] = 1'b0;
                  end else begin
                     res_in.status = ST_NOTFOUND;
                  end
               end
               MODE_POST: begin
                  if (!found_ff) begin
                     res_in.status = ST_NOTFOUND;
                  end else if (ent_len != '0) begin
                     ws_rd_en   = 1'b1;
                     ws_rd_addr = ws_addr(found_slot_ff, ent_head);
                     state_in   = S_WRD;
                  end else if (ent_count != '1) begin
                     slot_wr_en   = 1'b1;
                     slot_wr_addr = found_slot_ff;
                     slot_wr_data = {ent_ident, ent_count + 32'd1, ent_head, ent_len};
                  end
               end
               MODE_WAIT: begin
                  if (!found_ff) begin
                     res_in.status = ST_NOTFOUND;
                  end else if (ent_count != '0) begin
                     slot_wr_en     = 1'b1;
                     slot_wr_addr   = found_slot_ff;
                     slot_wr_data   = {ent_ident, ent_count - 32'd1, ent_head, ent_len};
                     res_in.granted = 1'b1;
                  end else if (ent_len == LW'(QUEUE_DEPTH)) begin
                     res_in.status = ST_QFULL;
                  end else begin
                     ws_wr_en       = 1'b1;
                     ws_wr_addr     = ws_addr(found_slot_ff,
                                      qwrap((LW+1)'(ent_head) + (LW+1)'(ent_len)));
                     ws_wr_data     = cmd_ff.proc_id;
                     slot_wr_en     = 1'b1;
                     slot_wr_addr   = found_slot_ff;
                     slot_wr_data   = {ent_ident, ent_count, ent_head, ent_len + LW'(1)};
                     res_in.blocked = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         S_CAND: begin
            // lowest id from 1 not named by any used slot; NUM_SEMS is taken unchecked if all below are named
            if (cand_ff < CW'(NUM_SEMS) && taken_ff[cand_ff[SW-1:0]]) begin
               cand_in = cand_ff + CW'(1);
            end else begin
               slot_wr_en            = 1'b1;
               slot_wr_addr          = free_slot_ff;
               slot_wr_data          = {16'(cand_ff), cmd_ff.init_value,
                                        {QW{1'b0}}, {LW{1'b0}}};
               used_in[free_slot_ff] = 1'b1;
               res_in.assigned_id    = 16'(cand_ff);
               state_in              = S_RESP;
            end
         end

         S_WRD: begin
            res_in.woken_valid = 1'b1;
            res_in.woken_proc  = ws_rd_data;
            slot_wr_en         = 1'b1;
            slot_wr_addr       = found_slot_ff;
            slot_wr_data       = {ent_ident, ent_count,
                                  qwrap((LW+1)'(ent_head) + (LW+1)'(1)),
                                  ent_len - LW'(1)};
            state_in           = S_RESP;
         end

         S_PSLOT: begin
            if (ps_ff == CW'(NUM_SEMS)) begin
               state_in = S_RESP;
            end else if (used_ff[ps_ff[SW-1:0]]) begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = ps_ff[SW-1:0];
               state_in     = S_PENT;
            end else begin
               ps_in = ps_ff + CW'(1);
            end
         end

         S_PENT: begin
            ent_in   = slot_rd_data;
            pi_in    = '0;
            pn_in    = '0;
            state_in = S_PRD;
         end

         S_PRD: begin
            if (pi_ff == ent_len) begin
               slot_wr_en   = 1'b1;
               slot_wr_addr = ps_ff[SW-1:0];
               slot_wr_data = {ent_ident, ent_count, ent_head, pn_ff};
               ps_in        = ps_ff + CW'(1);
               state_in     = S_PSLOT;
            end else begin
               ws_rd_en   = 1'b1;
               ws_rd_addr = ws_addr(ps_ff[SW-1:0],
                                    qwrap((LW+1)'(ent_head) + (LW+1)'(pi_ff)));
               state_in   = S_PWR;
            end
         end

         S_PWR: begin
            // keepers slide down; write slot never passes the read slot
            if (ws_rd_data != cmd_ff.proc_id) begin
               ws_wr_en   = 1'b1;
               ws_wr_addr = ws_addr(ps_ff[SW-1:0],
                                    qwrap((LW+1)'(ent_head) + (LW+1)'(pn_ff)));
               ws_wr_data = ws_rd_data;
               pn_in      = pn_ff + LW'(1);
            end
            pi_in    = pi_ff + LW'(1);
            state_in = S_PRD;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
      taken_ff      <= taken_in;
      scan_idx_ff   <= scan_idx_in;
      p_idx_ff      <= p_idx_in;
      found_ff      <= found_in;
      found_slot_ff <= found_slot_in;
      free_ok_ff    <= free_ok_in;
      free_slot_ff  <= free_slot_in;
      ent_ff        <= ent_in;
      cand_ff       <= cand_in;
      ps_ff         <= ps_in;
      pi_ff         <= pi_in;
      pn_ff         <= pn_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         p_vld_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         p_vld_ff     <= p_vld_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: verif/counting_semaphore_table_test.sv
// Self-checking testbench for counting_semaphore_table: directed table, queue and table fill, then random commands.
// Depends on csem_pkg and the counting_semaphore_table RTL.
module counting_semaphore_table_test;
   import csem_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NS = NUM_SEMS_DEF;
   localparam int QD = QUEUE_DEPTH_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   always #5 clock = ~clock;

   counting_semaphore_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   // ---- shadow semaphore table ----
   bit          sh_used  [NS];
   logic [15:0] sh_ident [NS];
   logic [31:0] sh_count [NS];
   logic [15:0] sh_waiters [NS][$];   // FIFO of waiting process ids per slot

   rsp_type expected_rsps[$];
   int      mismatches = 0;
   bit      rsp_idle_off = 1'b0;      // no stalls in the last part of the run
   int      watchdog = 0;

   function automatic int find_slot(logic [15:0] id);
      for (int i = 0; i < NS; i++)
         if (sh_used[i] && sh_ident[i] == id) return i;
      return -1;
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < NS; i++)
         if (!sh_used[i]) return i;
      return -1;
   endfunction

   // Applies one command to the shadow table and returns the result it must produce.
   function automatic rsp_type apply_command(req_type r);
      rsp_type     o;
      int          s;
      logic [15:0] cand;
      logic [15:0] kept[$];
      o = '0;
      o.status = ST_OK;
      case (r.mode)
         MODE_OPEN: begin
            if (find_slot(r.sem_id) < 0) begin
               s = free_slot();
               if (s < 0) o.status = ST_FULL;
               else begin
                  sh_used[s] = 1; sh_ident[s] = r.sem_id;
                  sh_count[s] = r.init_value; sh_waiters[s].delete();
               end
            end
         end
         MODE_OPEN_NEW: begin
            s = free_slot();
            if (s < 0) o.status = ST_FULL;
            else begin
               cand = 1;
               while (cand < NS && find_slot(cand) >= 0) cand++;
               sh_used[s] = 1; sh_ident[s] = cand;
               sh_count[s] = r.init_value; sh_waiters[s].delete();
               o.assigned_id = cand;
            end
         end
         MODE_CLOSE: begin
            s = find_slot(r.sem_id);
            if (s < 0) o.status = ST_NOTFOUND;
            else begin
               sh_used[s] = 0; sh_waiters[s].delete();
            end
         end
         MODE_POST: begin
            s = find_slot(r.sem_id);
            if (s < 0) o.status = ST_NOTFOUND;
            else if (sh_waiters[s].size() > 0) begin
               // unit goes straight to the oldest waiter
               o.woken_valid = 1;
               o.woken_proc = sh_waiters[s].pop_front();
            end else if (sh_count[s] != 32'hFFFF_FFFF) sh_count[s]++;
         end
         MODE_WAIT: begin
            s = find_slot(r.sem_id);
            if (s < 0) o.status = ST_NOTFOUND;
            else if (sh_count[s] > 0) begin
               sh_count[s]--; o.granted = 1;
            end else if (sh_waiters[s].size() >= QD) o.status = ST_QFULL;
            else begin
               sh_waiters[s].push_back(r.proc_id); o.blocked = 1;
            end
         end
         MODE_PURGE: begin
            for (int i = 0; i < NS; i++)
               if (sh_used[i]) begin
                  kept.delete();
                  foreach (sh_waiters[i][k])
                     if (sh_waiters[i][k] != r.proc_id) kept.push_back(sh_waiters[i][k]);
                  sh_waiters[i] = kept;
               end
         end
         default: ;   // unknown modes are ignored
      endcase
      return o;
   endfunction

   // ---- response side: random stalls, compare on each transfer ----
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_payload);
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (e !== rsp_payload) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: exp %p got %p", e, rsp_payload);
               end
            end
         end
      end
   end

   initial begin : rsp_driver
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!rsp_idle_off && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: cycles without any transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) watchdog <= 0;
      else if (!reset) begin
         watchdog <= watchdog + 1;
         if (watchdog >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Holds one command on the channel until it transfers; predicts on acceptance.
   task automatic send_command(req_type r, bit req_idle_on, bit has_fixed, rsp_type fixed);
      rsp_type p;
      int      n;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 11);
         repeat (n) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      p = apply_command(r);
      // typed-in rows also cross-check the predictor itself
      if (has_fixed && fixed !== p) begin
         mismatches++;
         if (mismatches <= 10) $display("table row: exp %p predicted %p", fixed, p);
      end
      expected_rsps.push_back(p);
   endtask

   function automatic req_type mk(mode_type m, logic [15:0] id, logic [31:0] v, logic [15:0] pid);
      req_type r;
      r.mode = m; r.sem_id = id; r.init_value = v; r.proc_id = pid;
      return r;
   endfunction

   function automatic rsp_type rs(status_type st, bit g, bit b, bit wv,
                                  logic [15:0] wp, logic [15:0] aid);
      rsp_type o;
      o.status = st; o.granted = g; o.blocked = b;
      o.woken_valid = wv; o.woken_proc = wp; o.assigned_id = aid;
      return o;
   endfunction

   // Directed table: command, whether a typed result applies, and that result.
   typedef struct {
      req_type cmd;
      bit      fixed;
      rsp_type res;
   } row_type;

   row_type tbl[$];

   // Random command biased toward a small pool of ids and processes.
   function automatic req_type random_command();
      req_type r;
      int      k;
      k = $urandom_range(0, 99);
      r.sem_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
      r.proc_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0: r.init_value = 0;
         1: r.init_value = 32'hFFFF_FFFF - $urandom_range(0, 2);
         2: r.init_value = $urandom;
         default: r.init_value = $urandom_range(0, 3);
      endcase
      if (k < 10) r.mode = MODE_OPEN;
      else if (k < 16) r.mode = MODE_OPEN_NEW;
      else if (k < 23) r.mode = MODE_CLOSE;
      else if (k < 55) r.mode = MODE_POST;
      else if (k < 92) r.mode = MODE_WAIT;
      else if (k < 97) r.mode = MODE_PURGE;
      else r.mode = mode_type'(3'($urandom_range(6, 7)));
      return r;
   endfunction

   initial begin : main
      int      total;
      req_type r;
      rsp_type z;
      z = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // after reset: nothing exists
      tbl.push_back('{mk(MODE_POST, 16'hFFFF, 0, 0), 1, rs(ST_NOTFOUND, 0, 0, 0, 0, 0)});
      tbl.push_back('{mk(MODE_WAIT, 16'h0000, 0, 16'hFFFF), 1, rs(ST_NOTFOUND, 0, 0, 0, 0, 0)});
      tbl.push_back('{mk(MODE_CLOSE, 16'h5555, 0, 0), 1, rs(ST_NOTFOUND, 0, 0, 0, 0, 0)});
      tbl.push_back('{mk(MODE_OPEN_NEW, 16'hAAAA, 32'hFFFF_FFFF, 0), 1, rs(ST_OK, 0, 0, 0, 0, 1)});
      // post at max count saturates; open of an existing id is a no-op
      tbl.push_back('{mk(MODE_POST, 16'h0001, 0, 0), 1, rs(ST_OK, 0, 0, 0, 0, 0)});
      tbl.push_back('{mk(MODE_OPEN, 16'h0001, 32'h0, 0), 1, rs(ST_OK, 0, 0, 0, 0, 0)});
      tbl.push_back('{mk(MODE_WAIT, 16'h0001, 0, 16'h1234), 1, rs(ST_OK, 1, 0, 0, 0, 0)});
      tbl.push_back('{mk(MODE_OPEN, 16'hFFFF, 32'h0, 0), 1, rs(ST_OK, 0, 0, 0, 0, 0)});
      tbl.push_back('{mk(MODE_WAIT, 16'hFFFF, 0, 16'hFFFF), 1, rs(ST_OK, 0, 1, 0, 0, 0)});
      tbl.push_back('{mk(MODE_WAIT, 16'hFFFF, 0, 16'h0000), 1, rs(ST_OK, 0, 1, 0, 0, 0)});
      tbl.push_back('{mk(MODE_WAIT, 16'hFFFF, 0, 16'hFFFF), 1, rs(ST_OK, 0, 1, 0, 0, 0)});
      // purge removes both copies and keeps the other waiter
      tbl.push_back('{mk(MODE_PURGE, 16'h7777, 32'hFFFF_FFFF, 16'hFFFF), 1, rs(ST_OK, 0, 0, 0, 0, 0)});
      tbl.push_back('{mk(MODE_POST, 16'hFFFF, 0, 0), 1, rs(ST_OK, 0, 0, 1, 16'h0000, 0)});
      tbl.push_back('{mk(MODE_POST, 16'hFFFF, 0, 0), 1, rs(ST_OK, 0, 0, 0, 0, 0)});
      tbl.push_back('{mk(mode_type'(3'd6), 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF), 1, z});
      tbl.push_back('{mk(mode_type'(3'd7), 16'h0, 0, 0), 1, z});
      tbl.push_back('{mk(MODE_CLOSE, 16'hFFFF, 0, 0), 1, rs(ST_OK, 0, 0, 0, 0, 0)});
      foreach (tbl[i]) send_command(tbl[i].cmd, 1'b0, tbl[i].fixed, tbl[i].res);

      // fill a queue to full, then fill the table (checked by the predictor)
      send_command(mk(MODE_OPEN, 16'h0BEE, 0, 0), 1, 0, z);
      for (int i = 0; i <= QD; i++)
         send_command(mk(MODE_WAIT, 16'h0BEE, 0, 16'(i)), 1, 0, z);
      for (int i = 0; i <= NS; i++)
         send_command(mk(MODE_OPEN_NEW, 16'h0, 32'(i), 0), 1, 0, z);
      send_command(mk(MODE_OPEN, 16'h4321, 0, 0), 1, 0, z);

      // hold off until every result is back
      req_valid <= 1'b0;
      wait (expected_rsps.size() == 0);
      @(posedge clock);

      // clear the table so random traffic starts with room
      for (int i = 0; i < NS; i++)
         if (sh_used[i]) send_command(mk(MODE_CLOSE, sh_ident[i], 0, 0), 1, 0, z);

      total = 1250;
      for (int n = 0; n < total; n++) begin
         if (n == total - 150) rsp_idle_off = 1'b1;
         r = random_command();
         send_command(r, n < total - 150, 0, z);
      end
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/csem_pkg.sv
rtl/core/csem_ram.sv
rtl/core/csem_ctrl.sv
rtl/core/counting_semaphore_table.sv
verif/counting_semaphore_table_test.sv
